// File: src/mnpd_pkg.sv
// Shared constants, types and the key-to-frequency function for the MIDI note decoder.
// No dependencies; imported by the decoder top level.
package mnpd_pkg;

    // MIDI status codes that act; every other status is ignored
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_BEND     = 8'hE0;

    localparam int KEY_COUNT      = 128;
    localparam int KEY_W          = $clog2(KEY_COUNT);
    localparam int FREQ_FRAC_BITS = 10;
    localparam int TABLE_FRAC     = 20;

    // Highest note (about 12.5 kHz) needs 14 integer bits
    localparam int NOTE_FREQ_W = 14 + FREQ_FRAC_BITS;
    localparam int FACTOR_W    = 15;
    localparam int FREQ_OUT_W  = 25;
    localparam int BEND_W      = 14;
    localparam int AMP_W       = 16;
    localparam int VEL_W       = 7;
    localparam int PROD_W      = (NOTE_FREQ_W + FACTOR_W > FREQ_OUT_W + 14) ?
                                 NOTE_FREQ_W + FACTOR_W : FREQ_OUT_W + 14;

    // Right shift applied to a table entry is SHIFT_BASE minus the octave index
    localparam int SHIFT_BASE = TABLE_FRAC - FREQ_FRAC_BITS + 10;

    // One octave of 440*2^(k/12) Hz with TABLE_FRAC fraction bits
    localparam logic [29:0] SEMITONE_HZ [12] = '{
        30'd461373440, 30'd488808132, 30'd517874176, 30'd548668578,
        30'd581294109, 30'd615859655, 30'd652480576, 30'd691279090,
        30'd732384684, 30'd775934544, 30'd822074013, 30'd870957077
    };

    // Message kind after status decode
    typedef enum logic [1:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_BEND
    } op_t;

    // Equal-tempered frequency of a key, rounded half up to FREQ_FRAC_BITS
    function automatic logic [NOTE_FREQ_W-1:0] key_to_freq(input logic [KEY_W-1:0] key);
        logic [7:0]  m;
        logic [15:0] prod;
        logic [3:0]  oct_idx;
        logic [7:0]  oct_base;
        logic [3:0]  semi;
        logic [29:0] t;
        logic [4:0]  sh;
        logic [30:0] sum;
        logic [30:0] shifted;
        // Offset key so that the octave index never goes negative
        m        = {1'b0, key} + 8'd51;
        // Divide by 12 through a reciprocal, exact over 0..178
        prod     = 16'(m) * 16'd171;
        oct_idx  = prod[14:11];
        oct_base = 8'({4'b0000, oct_idx} * 8'd12);
        semi     = 4'(m - oct_base);
        unique case (semi)
            4'd0:    t = SEMITONE_HZ[0];
            4'd1:    t = SEMITONE_HZ[1];
            4'd2:    t = SEMITONE_HZ[2];
            4'd3:    t = SEMITONE_HZ[3];
            4'd4:    t = SEMITONE_HZ[4];
            4'd5:    t = SEMITONE_HZ[5];
            4'd6:    t = SEMITONE_HZ[6];
            4'd7:    t = SEMITONE_HZ[7];
            4'd8:    t = SEMITONE_HZ[8];
            4'd9:    t = SEMITONE_HZ[9];
            4'd10:   t = SEMITONE_HZ[10];
            4'd11:   t = SEMITONE_HZ[11];
            default: t = '0;
        endcase
        sh = 5'(SHIFT_BASE - int'(oct_idx));
        if (sh == 5'd0)
        begin
            shifted = {1'b0, t};
        end
        else
        begin
            sum     = {1'b0, t} + (31'd1 << (sh - 5'd1));
            shifted = sum >> sh;
        end
        return NOTE_FREQ_W'(shifted);
    endfunction

endpackage

// File: src/midi_note_pitch_decoder_top.sv
// MIDI note on / note off / pitch bend decoder, top level.
// Depends on mnpd_pkg for status codes, widths and the key frequency function.

// One three-byte MIDI message per transaction, one result per message. Messages
// may follow every cycle while the result register is free. A result reaches the
// outputs through the input register (with the registered key table read), which
// catches the message, and then the result register, which loads the result once
// it is empty or taken. Only status 0x90, 0x80 and 0xE0 act. Key table entries
// read as zero from reset until written; there is no clearing pass. Frequency is
// unsigned with FREQ_FRAC_BITS fraction bits, amplitude unsigned Q1.15.
module midi_note_pitch_decoder_top
    import mnpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            status_byte,
    input  logic [KEY_W-1:0]      data_one,
    input  logic [VEL_W-1:0]      data_two,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [AMP_W-1:0]      amplitude,
    output logic [FREQ_OUT_W-1:0] frequency,
    output logic                  key_pressed,
    output logic [VEL_W-1:0]      key_velocity
);

    // Handshake state
    logic s1_valid_reg;
    logic out_valid_reg;
    logic in_accept;
    logic s1_advance;
    logic out_free;

    // Input stage payload
    op_t              op_reg;
    logic [KEY_W-1:0] d1_reg;
    logic [VEL_W-1:0] d2_reg;
    logic [VEL_W:0]   rd_entry_reg;
    logic             rd_valid_reg;

    // Key table: {pressed, velocity} per key, with a valid bit per key
    logic [VEL_W:0]         key_mem_reg [KEY_COUNT];
    logic [KEY_COUNT-1:0]   key_valid_reg;
    op_t                    in_op;

    // Decoder state
    logic [NOTE_FREQ_W-1:0] note_freq_reg;
    logic [NOTE_FREQ_W-1:0] note_freq_next;
    logic [AMP_W-1:0]       amp_reg;
    logic [AMP_W-1:0]       amp_next;
    logic [BEND_W-1:0]      bend_reg;
    logic [BEND_W-1:0]      bend_next;

    // Result datapath
    logic [AMP_W-1:0]       amp_calc;
    logic [8:0]             vel_rem;
    logic [FACTOR_W-1:0]    factor;
    logic [PROD_W-1:0]      freq_prod;
    logic                   pressed_next;
    logic [VEL_W-1:0]       vel_next;

    // Result register
    logic [AMP_W-1:0]       amp_out_reg;
    logic [FREQ_OUT_W-1:0]  freq_out_reg;
    logic                   pressed_out_reg;
    logic [VEL_W-1:0]       vel_out_reg;

    // Handshake: the result register frees when empty or taken
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    // Decode the status byte
    always_comb
    begin
        priority if (status_byte == STATUS_NOTE_ON)
            in_op = OP_NOTE_ON;
        else if (status_byte == STATUS_NOTE_OFF)
            in_op = OP_NOTE_OFF;
        else if (status_byte == STATUS_BEND)
            in_op = OP_BEND;
        else
            in_op = OP_NONE;
    end

    // Key table memory: write on note on/off, read the addressed entry
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_entry_reg <= key_mem_reg[data_one];
            if (in_op == OP_NOTE_ON)
                key_mem_reg[data_one] <= {1'b1, data_two};
            else if (in_op == OP_NOTE_OFF)
                key_mem_reg[data_one] <= '0;
        end
    end

    // Key valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            rd_valid_reg <= key_valid_reg[data_one];
            if (in_op == OP_NOTE_ON || in_op == OP_NOTE_OFF)
                key_valid_reg[data_one] <= 1'b1;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= in_op;
            d1_reg <= data_one;
            d2_reg <= data_two;
        end
    end

    // Amplitude: v*32768/127 rounded = 258*v + (2*v + 63)/127
    assign vel_rem  = {1'b0, d2_reg, 1'b0} + 9'd63;
    assign amp_calc = AMP_W'(16'(d2_reg) * 16'd258)
                    + ((vel_rem >= 9'd254) ? 16'd2 : (vel_rem >= 9'd127) ? 16'd1 : 16'd0);

    // Next decoder state
    always_comb
    begin
        note_freq_next = note_freq_reg;
        amp_next       = amp_reg;
        bend_next      = bend_reg;
        pressed_next   = rd_valid_reg & rd_entry_reg[VEL_W];
        vel_next       = rd_valid_reg ? rd_entry_reg[VEL_W-1:0] : '0;
        unique case (op_reg)
            OP_NOTE_ON:
            begin
                note_freq_next = key_to_freq(d1_reg);
                amp_next       = amp_calc;
                pressed_next   = 1'b1;
                vel_next       = d2_reg;
            end
            OP_NOTE_OFF:
            begin
                amp_next     = '0;
                pressed_next = 1'b0;
                vel_next     = '0;
            end
            OP_BEND:
            begin
                // raw - 8192 in 14-bit two's complement is a flip of the top bit
                bend_next = {d2_reg, d1_reg} ^ 14'h2000;
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Bent frequency: f*(16384 + bend)/16384, rounded half up
    assign factor    = FACTOR_W'(16384) + {bend_next[BEND_W-1], bend_next};
    assign freq_prod = PROD_W'(note_freq_next) * PROD_W'(factor) + PROD_W'(8192);

    // Hold control state and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            note_freq_reg <= '0;
            amp_reg       <= '0;
            bend_reg      <= '0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_advance)
            begin
                note_freq_reg <= note_freq_next;
                amp_reg       <= amp_next;
                bend_reg      <= bend_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            amp_out_reg     <= amp_next;
            freq_out_reg    <= freq_prod[14 +: FREQ_OUT_W];
            pressed_out_reg <= pressed_next;
            vel_out_reg     <= vel_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign amplitude    = amp_out_reg;
    assign frequency    = freq_out_reg;
    assign key_pressed  = pressed_out_reg;
    assign key_velocity = vel_out_reg;

endmodule

// File: src/mnpd_checker.sv
// Port-level checks for the MIDI note decoder, bound to its top level.
// Depends on mnpd_pkg for field widths.
module mnpd_checker
    import mnpd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [AMP_W-1:0]      amplitude,
    input logic [FREQ_OUT_W-1:0] frequency,
    input logic                  key_pressed,
    input logic [VEL_W-1:0]      key_velocity
);

    // Amplitude never exceeds unity
    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> amplitude <= AMP_W'(32768))
        else $error("amplitude above unity");

    // A nonzero stored velocity only belongs to a pressed key
    a_vel_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_velocity != '0) |-> key_pressed)
        else $error("velocity on a released key");

    // Input stalls only while a result waits to be taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // A stalled result holds its transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(amplitude)
            && $stable(frequency) && $stable(key_pressed) && $stable(key_velocity)))
        else $error("stalled result changed");

endmodule

bind midi_note_pitch_decoder_top mnpd_checker u_mnpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .amplitude    (amplitude),
    .frequency    (frequency),
    .key_pressed  (key_pressed),
    .key_velocity (key_velocity)
);

// File: tb/sv/midi_note_pitch_decoder_top_tb.sv
// Self-checking testbench for the MIDI note / pitch-bend decoder top level.
// Depends on mnpd_pkg and midi_note_pitch_decoder_top; predicts every result internally.
`timescale 1ns / 1ps

module midi_note_pitch_decoder_top_tb;
    import mnpd_pkg::*;

    // Statuses that must be ignored: other channels and non-voice codes
    localparam logic [7:0] STATUS_NOTE_ON_CH1  = 8'h91;
    localparam logic [7:0] STATUS_NOTE_OFF_CH1 = 8'h81;
    localparam logic [7:0] STATUS_BEND_CH1     = 8'hE1;
    localparam logic [7:0] STATUS_NOTE_OFF_CHF = 8'h8F;
    localparam logic [7:0] STATUS_NOTE_ON_CHF  = 8'h9F;
    localparam logic [7:0] STATUS_BEND_CHF     = 8'hEF;
    localparam logic [7:0] STATUS_SYSEX        = 8'hF0;
    localparam logic [7:0] STATUS_RESET        = 8'hFF;
    localparam logic [7:0] STATUS_ZERO         = 8'h00;

    localparam int  MAX_IDLE      = 13;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  RANDOM_ITEMS  = 1600;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  BEND_CENTER   = 8192;
    localparam int  AMP_FULL      = 32768;
    localparam int  VEL_TOP       = 127;

    typedef struct packed {
        logic [AMP_W-1:0]      amplitude;
        logic [FREQ_OUT_W-1:0] frequency;
        logic                  key_pressed;
        logic [VEL_W-1:0]      key_velocity;
    } voice_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            status_byte;
    logic [KEY_W-1:0]      data_one;
    logic [VEL_W-1:0]      data_two;
    logic                  out_valid;
    logic                  out_stall;
    logic [AMP_W-1:0]      amplitude;
    logic [FREQ_OUT_W-1:0] frequency;
    logic                  key_pressed;
    logic [VEL_W-1:0]      key_velocity;

    // Decoder model state
    logic [VEL_W-1:0] model_velocity [KEY_COUNT];
    logic             model_pressed  [KEY_COUNT];
    longint           model_note_freq;
    longint           model_amplitude;
    int               model_bend_raw;

    voice_report_t pending_reports [$];
    int            error_count;
    int            messages_sent;
    int            cycle_count;
    bit            tx_quiet;
    bit            rx_quiet;
    int            rx_wait;

    midi_note_pitch_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .amplitude    (amplitude),
        .frequency    (frequency),
        .key_pressed  (key_pressed),
        .key_velocity (key_velocity)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Equal-tempered key frequency with FREQ_FRAC_BITS fraction bits, rounded half up
    function automatic longint tempered_freq(input int key);
        int     m;
        int     octave;
        int     shift;
        longint entry;
        m      = key + 51;
        octave = m / 12 - 10;
        shift  = TABLE_FRAC - FREQ_FRAC_BITS - octave;
        entry  = longint'(SEMITONE_HZ[m % 12]);
        if (shift <= 0)
            return entry << (-shift);
        return (entry + (64'sd1 << (shift - 1))) >> shift;
    endfunction

    // Apply one message to the model and return the report it produces
    function automatic voice_report_t apply_message(input logic [7:0] st,
                                                    input logic [KEY_W-1:0] d1,
                                                    input logic [VEL_W-1:0] d2);
        voice_report_t rep;
        longint        bent;
        if (st == STATUS_NOTE_ON)
        begin
            model_note_freq   = tempered_freq(int'(d1));
            model_amplitude   = (longint'(d2) * AMP_FULL + VEL_TOP / 2) / VEL_TOP;
            model_pressed[d1]  = 1'b1;
            model_velocity[d1] = d2;
        end
        else if (st == STATUS_NOTE_OFF)
        begin
            model_amplitude    = 0;
            model_pressed[d1]  = 1'b0;
            model_velocity[d1] = '0;
        end
        else if (st == STATUS_BEND)
        begin
            model_bend_raw = (int'(d2) << 7) | int'(d1);
        end
        // Factor is 16384 plus the signed bend offset, i.e. raw bend plus 8192
        bent = (model_note_freq * longint'(model_bend_raw + BEND_CENTER) + 8192) >> 14;
        rep.amplitude    = AMP_W'(model_amplitude);
        rep.frequency    = FREQ_OUT_W'(bent);
        rep.key_pressed  = model_pressed[d1];
        rep.key_velocity = model_velocity[d1];
        return rep;
    endfunction

    function automatic int draw_idle(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Drive one message, hold it until accepted, then log its expected report
    task automatic send_message(input logic [7:0] st, input logic [KEY_W-1:0] d1,
                                input logic [VEL_W-1:0] d2);
        int gap;
        gap = draw_idle(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        status_byte <= st;
        data_one    <= d1;
        data_two    <= d2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reports.push_back(apply_message(st, d1, d2));
        messages_sent = messages_sent + 1;
    endtask

    // Check each accepted result and draw the next stall stretch
    always @(posedge clk)
    begin
        voice_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: amplitude %0d frequency %0d", amplitude, frequency);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (amplitude !== want.amplitude)
                begin
                    $error("amplitude: expected %0d, actual %0d", want.amplitude, amplitude);
                    error_count = error_count + 1;
                end
                if (frequency !== want.frequency)
                begin
                    $error("frequency: expected %0d, actual %0d", want.frequency, frequency);
                    error_count = error_count + 1;
                end
                if (key_pressed !== want.key_pressed)
                begin
                    $error("key_pressed: expected %0d, actual %0d", want.key_pressed,
                           key_pressed);
                    error_count = error_count + 1;
                end
                if (key_velocity !== want.key_velocity)
                begin
                    $error("key_velocity: expected %0d, actual %0d", want.key_velocity,
                           key_velocity);
                    error_count = error_count + 1;
                end
            end
            rx_wait = draw_idle(rx_quiet);
        end
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Idle-state reads, then the note extremes
    task automatic test_note_extremes();
        tx_quiet = 1'b0;
        send_message(STATUS_ZERO, 7'd0, 7'd0);
        send_message(STATUS_RESET, 7'd127, 7'd127);
        send_message(STATUS_NOTE_ON, 7'd0, 7'd0);
        send_message(STATUS_NOTE_ON, 7'd127, 7'd127);
        send_message(STATUS_NOTE_ON, 7'd69, 7'd64);
        send_message(STATUS_NOTE_OFF, 7'd127, 7'd127);
        send_message(STATUS_NOTE_OFF, 7'd5, 7'd0);
        send_message(STATUS_NOTE_ON, 7'd0, 7'd127);
    endtask

    // Bend extremes, center, and key fields read through a bend
    task automatic test_pitch_bend();
        tx_quiet = 1'b1;
        send_message(STATUS_BEND, 7'd0, 7'd0);
        send_message(STATUS_BEND, 7'd127, 7'd127);
        send_message(STATUS_BEND, 7'd0, 7'd64);
        send_message(STATUS_NOTE_ON, 7'd127, 7'd1);
        send_message(STATUS_BEND, 7'd127, 7'd0);
        send_message(STATUS_BEND, 7'd69, 7'd64);
        tx_quiet = 1'b0;
    endtask

    // Other channels and system statuses must leave the state alone
    task automatic test_ignored_statuses();
        send_message(STATUS_NOTE_ON_CH1, 7'd60, 7'd100);
        send_message(STATUS_NOTE_OFF_CH1, 7'd0, 7'd0);
        send_message(STATUS_BEND_CH1, 7'd0, 7'd0);
        send_message(STATUS_NOTE_OFF_CHF, 7'd127, 7'd0);
        send_message(STATUS_NOTE_ON_CHF, 7'd1, 7'd127);
        send_message(STATUS_BEND_CHF, 7'd127, 7'd127);
        send_message(STATUS_SYSEX, 7'd0, 7'd127);
        send_message(STATUS_ZERO, 7'd127, 7'd127);
    endtask

    // Mostly well-formed phrases (on, bends, off) with noise messages mixed in
    task automatic test_random_messages(input int count);
        int               stop_at;
        int               bends;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] key_pool [8];
        key_pool = '{7'd0, 7'd1, 7'd35, 7'd60, 7'd69, 7'd70, 7'd126, 7'd127};
        stop_at  = messages_sent + count;
        while (messages_sent < stop_at)
        begin
            // Switch idle stretches on and off now and then
            if ($urandom_range(0, 39) == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 39) == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) < 15)
            begin
                send_message(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)));
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    key = 7'($urandom_range(0, 127));
                else
                    key = key_pool[$urandom_range(0, 7)];
                send_message(STATUS_NOTE_ON, key, 7'($urandom_range(0, 127)));
                bends = $urandom_range(0, 3);
                repeat (bends)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_message(STATUS_BEND, key, 7'($urandom_range(0, 127)));
                    else
                        send_message(STATUS_BEND, 7'($urandom_range(0, 127)),
                                     7'($urandom_range(0, 127)));
                end
                if ($urandom_range(0, 9) != 0)
                    send_message(STATUS_NOTE_OFF, key, 7'($urandom_range(0, 127)));
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        status_byte   = '0;
        data_one      = '0;
        data_two      = '0;
        out_stall     = 1'b0;
        error_count   = 0;
        messages_sent = 0;
        cycle_count   = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        rx_wait       = 0;
        model_note_freq = 0;
        model_amplitude = 0;
        model_bend_raw  = BEND_CENTER;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            model_velocity[i] = '0;
            model_pressed[i]  = 1'b0;
        end

        // Hold reset asserted, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_note_extremes();
        test_pitch_bend();
        test_ignored_statuses();
        test_random_messages(RANDOM_ITEMS);

        // Drop valid and drain the remaining results
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_reports.size());
            error_count = error_count + 1;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
